[hdl/pngcsp_pkg.sv]
`timescale 1ns / 1ps

package pngcsp_pkg;

   // Palette geometry. Entries are 24-bit RGB.
   localparam int PAL_DEPTH    = 256;
   localparam int PAL_AW       = $clog2(PAL_DEPTH);
   localparam int PLTE_MAX_LEN = 3 * PAL_DEPTH;
   // Bits of the chunk length that the palette length check looks at; PLTE_MAX_LEN fits.
   localparam int LEN_CHK_W    = 10;

   localparam logic [7:0] COLOUR_GREY       = 8'd0;
   localparam logic [7:0] COLOUR_INDEXED    = 8'd3;
   localparam logic [7:0] COLOUR_GREY_ALPHA = 8'd4;

   localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
   localparam logic [31:0] TYPE_PLTE = 32'h504C_5445;
   localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
   localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;
   localparam logic [31:0] TYPE_CHRM = 32'h6348_524D;
   localparam logic [31:0] TYPE_BKGD = 32'h624B_4744;
   localparam logic [31:0] TYPE_TIME = 32'h7449_4D45;
   localparam logic [31:0] TYPE_TEXT = 32'h7445_5874;

   typedef enum logic [2:0] {
      PH_SIG  = 3'd0,
      PH_LEN  = 3'd1,
      PH_TYPE = 3'd2,
      PH_PAY  = 3'd3,
      PH_CRC  = 3'd4,
      PH_END  = 3'd5,
      PH_ERR  = 3'd6
   } phase_type;

   typedef enum logic [3:0] {
      K_IHDR = 4'd0,
      K_PLTE = 4'd1,
      K_IDAT = 4'd2,
      K_IEND = 4'd3,
      K_CHRM = 4'd4,
      K_BKGD = 4'd5,
      K_TIME = 4'd6,
      K_TEXT = 4'd7,
      K_NONE = 4'd8
   } kind_type;

   typedef enum logic [2:0] {
      F_OK    = 3'd0,
      F_SIG   = 3'd1,
      F_ORDER = 3'd2,
      F_LEN   = 3'd3,
      F_PLTE  = 3'd4,
      F_TYPE  = 3'd5
   } fault_type;

   // Palette memory request: one write port and one read port.
   typedef struct packed {
      logic              wr_en;
      logic [PAL_AW-1:0] wr_addr;
      logic [23:0]       wr_data;
      logic              rd_en;
      logic [PAL_AW-1:0] rd_addr;
      logic              rd_hit;
   } pal_req_type;

   function automatic logic [7:0] sig_byte(input logic [2:0] idx);
      logic [7:0] val;
      unique case (idx)
         3'd0:    val = 8'h89;
         3'd1:    val = 8'h50;
         3'd2:    val = 8'h4E;
         3'd3:    val = 8'h47;
         3'd4:    val = 8'h0D;
         3'd5:    val = 8'h0A;
         3'd6:    val = 8'h1A;
         default: val = 8'h0A;
      endcase
      return val;
   endfunction

   function automatic kind_type classify(input logic [31:0] code);
      kind_type k;
      unique case (code)
         TYPE_IHDR: k = K_IHDR;
         TYPE_PLTE: k = K_PLTE;
         TYPE_IDAT: k = K_IDAT;
         TYPE_IEND: k = K_IEND;
         TYPE_CHRM: k = K_CHRM;
         TYPE_BKGD: k = K_BKGD;
         TYPE_TIME: k = K_TIME;
         TYPE_TEXT: k = K_TEXT;
         default:   k = K_NONE;
      endcase
      return k;
   endfunction

endpackage

[hdl/pngcsp_palette.sv]
`timescale 1ns / 1ps

// Palette memory: one write and one registered read per cycle.
module pngcsp_palette (
   input  logic                     clock,
   input  pngcsp_pkg::pal_req_type  pal_req,
   output logic [23:0]              rd_data
);

   logic [23:0] pal_mem [pngcsp_pkg::PAL_DEPTH];
   logic [23:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (pal_req.wr_en) begin
         pal_mem[pal_req.wr_addr] <= pal_req.wr_data;
      end
   end

   // An index beyond the palette reads as zero.
   always_ff @(posedge clock) begin
      if (pal_req.rd_en) begin
         rd_data_ff <= pal_req.rd_hit ? pal_mem[pal_req.rd_addr] : 24'd0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/png_chunk_stream_parser.sv]
`timescale 1ns / 1ps

// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+------------------------------------------
// req_      | in        | req_valid/req_ready  | stream_byte, one file byte per word
// rsp_      | out       | rsp_valid/rsp_ready  | phase, kind, byte, IDAT flag, IHDR fields,
//           |           |                      | background, fault code (one word per byte)
//
// One byte is accepted per cycle unless a result word is stalled; its result word appears
// in the output register in the cycle after acceptance. The rate is set by the state
// update and the one palette access per byte, whose registered read lands with the
// result word. Reset is synchronous and takes effect at once; the palette memory is
// not cleared. On low rsp_ready a pending word holds and req_ready drops in the same cycle.
module png_chunk_stream_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_parse_phase,
   output logic [3:0]  rsp_chunk_kind,
   output logic [7:0]  rsp_payload_out,
   output logic        rsp_compressed_valid,
   output logic [31:0] rsp_image_width,
   output logic [31:0] rsp_image_height,
   output logic [7:0]  rsp_sample_depth,
   output logic [7:0]  rsp_colour_kind,
   output logic [15:0] rsp_back_red,
   output logic [15:0] rsp_back_green,
   output logic [15:0] rsp_back_blue,
   output logic [2:0]  rsp_fault_code
);

   localparam int AW = pngcsp_pkg::PAL_AW;

   // Parser state. The IHDR fields, background and fault code are read straight from
   // these registers by the result word: they only change when the next byte is
   // accepted, which is also the edge at which the pending result word is taken.
   pngcsp_pkg::phase_type phase_ff, phase_in;
   pngcsp_pkg::kind_type  kind_ff, kind_in;
   pngcsp_pkg::fault_type fault_ff, fault_in;
   logic [30:0]           cnt_ff, cnt_in;
   logic [31:0]           len_ff, len_in;
   logic [23:0]           type_ff, type_in;
   logic                  header_ff, header_in;
   logic [31:0]           width_ff, width_in;
   logic [31:0]           height_ff, height_in;
   logic [7:0]            depth_ff, depth_in;
   logic [7:0]            colour_ff, colour_in;
   logic [15:0]           partial_ff, partial_in;
   logic [1:0]            pal_sub_ff, pal_sub_in;
   logic [AW-1:0]         pal_entry_ff, pal_entry_in;
   logic [2:0][15:0]      bg_ff, bg_in;
   logic                  bg_mem_ff, bg_mem_in;

   // Output register for the per-byte part of the result word.
   logic                  rsp_valid_ff;
   pngcsp_pkg::phase_type rsp_phase_ff, rsp_phase_in;
   pngcsp_pkg::kind_type  rsp_kind_ff, rsp_kind_in;
   logic [7:0]            rsp_byte_ff;
   logic                  rsp_comp_ff, rsp_comp_in;

   logic                  accept;
   logic                  ended;
   logic [31:0]           len_word;
   logic [31:0]           type_word;
   pngcsp_pkg::kind_type  kind_id;
   pngcsp_pkg::fault_type type_fault;
   logic                  plte_len_ok;
   logic                  pay_last;
   logic [2:0][15:0]      bg_cur;
   logic [23:0]           pal_rd_data;
   pngcsp_pkg::pal_req_type pal_req;

   function automatic logic mod3_zero(input logic [pngcsp_pkg::LEN_CHK_W-1:0] v);
      logic [3:0] s;
      logic [2:0] t;
      // Base-4 digit sum keeps the residue modulo 3.
      s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]) + 4'(v[9:8]);
      t = 3'(s[3:2]) + 3'(s[1:0]);
      return (t == 3'd0) || (t == 3'd3) || (t == 3'd6);
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;

   // Length and type words as they stand after the current byte.
   assign len_word  = {((cnt_ff == 31'd0) ? 24'd0 : len_ff[23:0]), req_stream_byte};
   assign type_word = {type_ff, req_stream_byte};
   assign kind_id   = pngcsp_pkg::classify(type_word);
   assign pay_last  = (32'(cnt_ff) + 32'd1) >= len_ff;

   assign plte_len_ok = (len_ff <= 32'(pngcsp_pkg::PLTE_MAX_LEN))
                        && mod3_zero(len_ff[pngcsp_pkg::LEN_CHK_W-1:0]);

   // A palette lookup lands in the read register in the cycle after it is issued; until
   // the next byte folds it into bg_ff, the background is taken from there.
   always_comb begin
      if (bg_mem_ff) begin
         bg_cur[0] = {8'd0, pal_rd_data[23:16]};
         bg_cur[1] = {8'd0, pal_rd_data[15:8]};
         bg_cur[2] = {8'd0, pal_rd_data[7:0]};
      end else begin
         bg_cur = bg_ff;
      end
   end

   // Fault raised by the type that the fourth type byte completes.
   always_comb begin
      type_fault = pngcsp_pkg::F_OK;
      if (!header_ff) begin
         if (kind_id != pngcsp_pkg::K_IHDR) begin
            type_fault = pngcsp_pkg::F_ORDER;
         end
      end else if ((kind_id == pngcsp_pkg::K_IHDR) || (kind_id == pngcsp_pkg::K_NONE)) begin
         type_fault = pngcsp_pkg::F_TYPE;
      end else if ((kind_id == pngcsp_pkg::K_PLTE) && !plte_len_ok) begin
         type_fault = pngcsp_pkg::F_PLTE;
      end
   end

   // Next state: framing phase, field counter and fault.
   always_comb begin
      phase_in = phase_ff;
      fault_in = fault_ff;
      cnt_in   = cnt_ff;
      ended    = 1'b0;
      unique case (phase_ff)
         pngcsp_pkg::PH_SIG: begin
            if (req_stream_byte != pngcsp_pkg::sig_byte(cnt_ff[2:0])) begin
               phase_in = pngcsp_pkg::PH_ERR;
               fault_in = pngcsp_pkg::F_SIG;
            end else if (cnt_ff == 31'd7) begin
               phase_in = pngcsp_pkg::PH_LEN;
               cnt_in   = 31'd0;
            end else begin
               cnt_in = cnt_ff + 31'd1;
            end
         end
         pngcsp_pkg::PH_LEN: begin
            if (cnt_ff == 31'd3) begin
               cnt_in = 31'd0;
               if (len_word[31]) begin
                  phase_in = pngcsp_pkg::PH_ERR;
                  fault_in = pngcsp_pkg::F_LEN;
               end else begin
                  phase_in = pngcsp_pkg::PH_TYPE;
               end
            end else begin
               cnt_in = cnt_ff + 31'd1;
            end
         end
         pngcsp_pkg::PH_TYPE: begin
            if (cnt_ff != 31'd3) begin
               cnt_in = cnt_ff + 31'd1;
            end else begin
               cnt_in = 31'd0;
               if (type_fault != pngcsp_pkg::F_OK) begin
                  phase_in = pngcsp_pkg::PH_ERR;
                  fault_in = type_fault;
               end else if (len_ff == 32'd0) begin
                  phase_in = pngcsp_pkg::PH_CRC;
               end else begin
                  phase_in = pngcsp_pkg::PH_PAY;
               end
            end
         end
         pngcsp_pkg::PH_PAY: begin
            if (pay_last) begin
               cnt_in   = 31'd0;
               phase_in = pngcsp_pkg::PH_CRC;
            end else begin
               cnt_in = cnt_ff + 31'd1;
            end
         end
         pngcsp_pkg::PH_CRC: begin
            if (cnt_ff != 31'd3) begin
               cnt_in = cnt_ff + 31'd1;
            end else begin
               cnt_in = 31'd0;
               if (kind_ff == pngcsp_pkg::K_IEND) begin
                  ended    = 1'b1;
                  phase_in = pngcsp_pkg::PH_SIG;
               end else begin
                  phase_in = pngcsp_pkg::PH_LEN;
               end
            end
         end
         default: begin
            phase_in = pngcsp_pkg::PH_ERR;
         end
      endcase
   end

   // Outputs of the state machine: chunk fields, palette traffic and the result word.
   always_comb begin
      len_in       = len_ff;
      type_in      = type_ff;
      kind_in      = kind_ff;
      header_in    = header_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      depth_in     = depth_ff;
      colour_in    = colour_ff;
      partial_in   = partial_ff;
      pal_sub_in   = pal_sub_ff;
      pal_entry_in = pal_entry_ff;
      bg_in        = bg_cur;
      bg_mem_in    = 1'b0;
      rsp_comp_in  = 1'b0;
      pal_req      = '0;

      unique case (phase_ff)
         pngcsp_pkg::PH_LEN: begin
            if (cnt_ff == 31'd0) begin
               kind_in = pngcsp_pkg::K_NONE;
            end
            len_in = len_word;
         end
         pngcsp_pkg::PH_TYPE: begin
            type_in = type_word[23:0];
            if (cnt_ff == 31'd3) begin
               kind_in      = (type_fault == pngcsp_pkg::F_TYPE) ? pngcsp_pkg::K_NONE : kind_id;
               pal_sub_in   = 2'd0;
               pal_entry_in = '0;
               if (!header_ff && (kind_id == pngcsp_pkg::K_IHDR)) begin
                  header_in = 1'b1;
                  width_in  = 32'd0;
                  height_in = 32'd0;
                  depth_in  = 8'd0;
                  colour_in = 8'd0;
               end
               if ((type_fault == pngcsp_pkg::F_OK) && (kind_id == pngcsp_pkg::K_BKGD)) begin
                  bg_in = '0;
               end
            end
         end
         pngcsp_pkg::PH_PAY: begin
            rsp_comp_in = (kind_ff == pngcsp_pkg::K_IDAT);
            case (kind_ff)
               pngcsp_pkg::K_IHDR: begin
                  if (cnt_ff < 31'd4) begin
                     width_in = {width_ff[23:0], req_stream_byte};
                  end else if (cnt_ff < 31'd8) begin
                     height_in = {height_ff[23:0], req_stream_byte};
                  end else if (cnt_ff == 31'd8) begin
                     depth_in = req_stream_byte;
                  end else if (cnt_ff == 31'd9) begin
                     colour_in = req_stream_byte;
                  end
               end
               pngcsp_pkg::K_PLTE: begin
                  // Red, green, then blue completes the entry and writes it.
                  case (pal_sub_ff)
                     2'd0: begin
                        partial_in = {req_stream_byte, 8'd0};
                        pal_sub_in = 2'd1;
                     end
                     2'd1: begin
                        partial_in = {partial_ff[15:8], req_stream_byte};
                        pal_sub_in = 2'd2;
                     end
                     default: begin
                        pal_req.wr_en   = accept;
                        pal_req.wr_addr = pal_entry_ff;
                        pal_req.wr_data = {partial_ff, req_stream_byte};
                        pal_sub_in      = 2'd0;
                        pal_entry_in    = pal_entry_ff + AW'(1);
                     end
                  endcase
               end
               pngcsp_pkg::K_BKGD: begin
                  if (colour_ff == pngcsp_pkg::COLOUR_INDEXED) begin
                     if (cnt_ff == 31'd0) begin
                        pal_req.rd_en   = accept;
                        pal_req.rd_addr = req_stream_byte[AW-1:0];
                        pal_req.rd_hit  = {1'b0, req_stream_byte} < 9'(pngcsp_pkg::PAL_DEPTH);
                        bg_mem_in       = 1'b1;
                     end
                  end else if ((colour_ff == pngcsp_pkg::COLOUR_GREY)
                               || (colour_ff == pngcsp_pkg::COLOUR_GREY_ALPHA)) begin
                     if (cnt_ff < 31'd2) begin
                        bg_in[0] = {bg_cur[0][7:0], req_stream_byte};
                        bg_in[1] = {bg_cur[1][7:0], req_stream_byte};
                        bg_in[2] = {bg_cur[2][7:0], req_stream_byte};
                     end
                  end else if (cnt_ff < 31'd6) begin
                     bg_in[cnt_ff[2:1]] = {bg_cur[cnt_ff[2:1]][7:0], req_stream_byte};
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase

      // The result word shows the kind before the end of IEND clears it.
      rsp_kind_in = kind_in;
      if (ended) begin
         kind_in   = pngcsp_pkg::K_NONE;
         header_in = 1'b0;
      end

      rsp_phase_in = ended ? pngcsp_pkg::PH_END : phase_ff;
      if (phase_in == pngcsp_pkg::PH_ERR) begin
         rsp_phase_in = pngcsp_pkg::PH_ERR;
         rsp_comp_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= pngcsp_pkg::PH_SIG;
         kind_ff      <= pngcsp_pkg::K_NONE;
         fault_ff     <= pngcsp_pkg::F_OK;
         cnt_ff       <= 31'd0;
         len_ff       <= 32'd0;
         type_ff      <= 24'd0;
         header_ff    <= 1'b0;
         width_ff     <= 32'd0;
         height_ff    <= 32'd0;
         depth_ff     <= 8'd0;
         colour_ff    <= 8'd0;
         partial_ff   <= 16'd0;
         pal_sub_ff   <= 2'd0;
         pal_entry_ff <= '0;
         bg_ff        <= '0;
         bg_mem_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         kind_ff      <= kind_in;
         fault_ff     <= fault_in;
         cnt_ff       <= cnt_in;
         len_ff       <= len_in;
         type_ff      <= type_in;
         header_ff    <= header_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         depth_ff     <= depth_in;
         colour_ff    <= colour_in;
         partial_ff   <= partial_in;
         pal_sub_ff   <= pal_sub_in;
         pal_entry_ff <= pal_entry_in;
         bg_ff        <= bg_in;
         bg_mem_ff    <= bg_mem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_phase_ff <= rsp_phase_in;
         rsp_kind_ff  <= rsp_kind_in;
         rsp_byte_ff  <= req_stream_byte;
         rsp_comp_ff  <= rsp_comp_in;
      end
   end

   pngcsp_palette u_palette (
      .clock   (clock),
      .pal_req (pal_req),
      .rd_data (pal_rd_data)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_parse_phase      = rsp_phase_ff;
   assign rsp_chunk_kind       = rsp_kind_ff;
   assign rsp_payload_out      = rsp_byte_ff;
   assign rsp_compressed_valid = rsp_comp_ff;
   assign rsp_image_width      = width_ff;
   assign rsp_image_height     = height_ff;
   assign rsp_sample_depth     = depth_ff;
   assign rsp_colour_kind      = colour_ff;
   assign rsp_back_red         = bg_cur[0];
   assign rsp_back_green       = bg_cur[1];
   assign rsp_back_blue        = bg_cur[2];
   assign rsp_fault_code       = fault_ff;

   // The error phase is sticky until reset.
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == pngcsp_pkg::PH_ERR) |=> (phase_ff == pngcsp_pkg::PH_ERR))
      else $error("parser left the error phase");

   // A fault code is recorded exactly when the parser is in the error phase.
   a_fault_matches_phase: assert property (@(posedge clock) disable iff (reset)
      (fault_ff != pngcsp_pkg::F_OK) == (phase_ff == pngcsp_pkg::PH_ERR))
      else $error("fault code and phase disagree");

   // Compressed words only come from IDAT payload.
   a_comp_only_idat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_comp_ff) |->
         ((rsp_kind_ff == pngcsp_pkg::K_IDAT) && (rsp_phase_ff == pngcsp_pkg::PH_PAY)))
      else $error("compressed flag outside IDAT payload");

   // A pending palette lookup only follows an indexed bKGD byte.
   a_lookup_indexed: assert property (@(posedge clock) disable iff (reset)
      bg_mem_ff |-> ((colour_ff == pngcsp_pkg::COLOUR_INDEXED)
                     && (kind_ff == pngcsp_pkg::K_BKGD)))
      else $error("palette lookup outside indexed bKGD");

endmodule

[verif/png_parse_check_pkg.sv]
`timescale 1ns / 1ps

package png_parse_check_pkg;

   import pngcsp_pkg::*;

   // The eight signature bytes, first byte in the top lane.
   localparam logic [63:0] PNG_MAGIC = 64'h8950_4E47_0D0A_1A0A;
   localparam logic [31:0] LEN_LIMIT = 32'h7FFF_FFFF;

   typedef struct {
      logic [2:0]  phase;
      logic [3:0]  kind;
      logic [7:0]  data;
      logic        idat;
      logic [31:0] width;
      logic [31:0] height;
      logic [7:0]  depth;
      logic [7:0]  colour;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [2:0]  fault;
   } parse_word_type;

   class png_stream_scoreboard;
      phase_type   phase;
      kind_type    kind;
      fault_type   fault;
      bit [31:0]   count;
      bit [31:0]   length;
      bit [31:0]   type_code;
      bit [31:0]   width;
      bit [31:0]   height;
      bit [7:0]    depth;
      bit [7:0]    colour;
      bit [23:0]   palette [PAL_DEPTH];
      bit [15:0]   entry_hi;
      bit [15:0]   back [3];
      bit          header_seen;
      parse_word_type awaited_words [$];
      int          mismatches;
      int          words_seen;

      function new();
         phase = PH_SIG;
         kind = K_NONE;
         fault = F_OK;
         count = 0;
         length = 0;
         type_code = 0;
         width = 0;
         height = 0;
         depth = 0;
         colour = 0;
         entry_hi = 0;
         header_seen = 1'b0;
         mismatches = 0;
         words_seen = 0;
         foreach (palette[i]) palette[i] = '0;
         foreach (back[i]) back[i] = '0;
      endfunction

      function void enter_fault(fault_type code);
         phase = PH_ERR;
         fault = code;
      endfunction

      // Advances the parse state by one accepted byte and queues the word it must produce.
      function void take_byte(logic [7:0] b);
         parse_word_type w;
         phase_type   role;
         kind_type    shown;
         bit          idat;
         bit          ended;
         bit [23:0]   entry;
         role = phase;
         idat = 1'b0;
         ended = 1'b0;
         case (phase)
            PH_SIG: begin
               if (b != PNG_MAGIC[63 - 8 * count[2:0] -: 8]) begin
                  enter_fault(F_SIG);
               end else if (count >= 7) begin
                  phase = PH_LEN;
                  count = 0;
               end else begin
                  count++;
               end
            end
            PH_LEN: begin
               if (count == 0) begin
                  kind = K_NONE;
                  length = 0;
               end
               length = {length[23:0], b};
               if (count >= 3) begin
                  count = 0;
                  if (length > LEN_LIMIT) enter_fault(F_LEN);
                  else phase = PH_TYPE;
               end else begin
                  count++;
               end
            end
            PH_TYPE: begin
               type_code = {type_code[23:0], b};
               if (count < 3) begin
                  count++;
               end else begin
                  count = 0;
                  case (type_code)
                     TYPE_IHDR: kind = K_IHDR;
                     TYPE_PLTE: kind = K_PLTE;
                     TYPE_IDAT: kind = K_IDAT;
                     TYPE_IEND: kind = K_IEND;
                     TYPE_CHRM: kind = K_CHRM;
                     TYPE_BKGD: kind = K_BKGD;
                     TYPE_TIME: kind = K_TIME;
                     TYPE_TEXT: kind = K_TEXT;
                     default:   kind = K_NONE;
                  endcase
                  if (!header_seen && kind != K_IHDR) begin
                     enter_fault(F_ORDER);
                  end else if (header_seen && (kind == K_IHDR || kind == K_NONE)) begin
                     kind = K_NONE;
                     enter_fault(F_TYPE);
                  end else if (kind == K_PLTE &&
                               (length % 3 != 0 || length > PLTE_MAX_LEN)) begin
                     enter_fault(F_PLTE);
                  end else begin
                     if (kind == K_IHDR) begin
                        header_seen = 1'b1;
                        width = 0;
                        height = 0;
                        depth = 0;
                        colour = 0;
                     end
                     if (kind == K_BKGD) foreach (back[i]) back[i] = '0;
                     phase = (length == 0) ? PH_CRC : PH_PAY;
                  end
               end
            end
            PH_PAY: begin
               idat = (kind == K_IDAT);
               case (kind)
                  K_IHDR: begin
                     if (count < 4) width = {width[23:0], b};
                     else if (count < 8) height = {height[23:0], b};
                     else if (count == 8) depth = b;
                     else if (count == 9) colour = b;
                  end
                  K_PLTE: begin
                     case (count % 3)
                        0: entry_hi = {b, 8'h00};
                        1: entry_hi[7:0] = b;
                        default: if (count / 3 < PAL_DEPTH) palette[count / 3] = {entry_hi, b};
                     endcase
                  end
                  K_BKGD: begin
                     if (colour == COLOUR_INDEXED) begin
                        if (count == 0) begin
                           entry = (b < PAL_DEPTH) ? palette[b] : '0;
                           back[0] = {8'h00, entry[23:16]};
                           back[1] = {8'h00, entry[15:8]};
                           back[2] = {8'h00, entry[7:0]};
                        end
                     end else if (colour == COLOUR_GREY || colour == COLOUR_GREY_ALPHA) begin
                        if (count < 2) foreach (back[i]) back[i] = {back[i][7:0], b};
                     end else if (count < 6) begin
                        back[count / 2] = {back[count / 2][7:0], b};
                     end
                  end
                  default: ;
               endcase
               if (count + 1 >= length) begin
                  count = 0;
                  phase = PH_CRC;
               end else begin
                  count++;
               end
            end
            PH_CRC: begin
               if (count < 3) begin
                  count++;
               end else begin
                  count = 0;
                  if (kind == K_IEND) begin
                     ended = 1'b1;
                     phase = PH_SIG;
                     header_seen = 1'b0;
                  end else begin
                     phase = PH_LEN;
                  end
               end
            end
            default: phase = PH_ERR;
         endcase
         shown = kind;
         if (ended) begin
            role = PH_END;
            kind = K_NONE;
         end
         if (phase == PH_ERR) begin
            role = PH_ERR;
            idat = 1'b0;
         end
         w.phase = role;
         w.kind = shown;
         w.data = b;
         w.idat = idat;
         w.width = width;
         w.height = height;
         w.depth = depth;
         w.colour = colour;
         w.red = back[0];
         w.green = back[1];
         w.blue = back[2];
         w.fault = fault;
         awaited_words.push_back(w);
      endfunction

      function string field_diff(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) return $sformatf(" %s exp %0h got %0h", name, want, got);
         return "";
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) $display("MISMATCH at word %0d:%s", words_seen, msg);
      endfunction

      function void check_word(parse_word_type got);
         parse_word_type want;
         string       diffs;
         words_seen++;
         if (awaited_words.size() == 0) begin
            report(" result word with no byte outstanding");
            return;
         end
         want = awaited_words.pop_front();
         diffs = {field_diff("phase", want.phase, got.phase),
                  field_diff("kind", want.kind, got.kind),
                  field_diff("byte", want.data, got.data),
                  field_diff("idat", want.idat, got.idat),
                  field_diff("width", want.width, got.width),
                  field_diff("height", want.height, got.height),
                  field_diff("depth", want.depth, got.depth),
                  field_diff("colour", want.colour, got.colour),
                  field_diff("red", want.red, got.red),
                  field_diff("green", want.green, got.green),
                  field_diff("blue", want.blue, got.blue),
                  field_diff("fault", want.fault, got.fault)};
         if (diffs != "") report(diffs);
      endfunction

      function int pending();
         return awaited_words.size();
      endfunction
   endclass

endpackage

[verif/tb_top.sv]
`timescale 1ns / 1ps

// Byte-level test of the chunk parser. Every byte accepted on the request side is
// run through the scoreboard's own parse model, and every result word is compared
// field by field with the oldest word that model has queued.
module tb_top;

   import pngcsp_pkg::*;
   import png_parse_check_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_BYTES = 220;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 8;

   // Truecolour types; they take the RGB path of bKGD like any other non-grey, non-indexed type.
   localparam logic [7:0] COLOUR_RGB       = 8'd2;
   localparam logic [7:0] COLOUR_RGB_ALPHA = 8'd6;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_stream_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_parse_phase;
   logic [3:0]  rsp_chunk_kind;
   logic [7:0]  rsp_payload_out;
   logic        rsp_compressed_valid;
   logic [31:0] rsp_image_width;
   logic [31:0] rsp_image_height;
   logic [7:0]  rsp_sample_depth;
   logic [7:0]  rsp_colour_kind;
   logic [15:0] rsp_back_red;
   logic [15:0] rsp_back_green;
   logic [15:0] rsp_back_blue;
   logic [2:0]  rsp_fault_code;

   png_stream_scoreboard board = new;

   // When quiet is set neither side inserts idle cycles any more.
   bit         quiet;
   bit         long_hold_done;
   int         bytes_sent;
   int         cycle_count;
   // Palette entries 0 .. pal_filled-1 have been written at least once. The palette
   // is never cleared, so an indexed bKGD may only name one of these entries.
   int         pal_filled;
   // Colour type the block holds after the last IHDR that was sent.
   logic [7:0] cur_colour;

   png_chunk_stream_parser dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // A run that hangs anywhere ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Both channels are observed at the rising edge, before the block's own registers
   // update, so a word counts exactly when valid and ready were high together.
   always @(posedge clock) begin
      parse_word_type got;
      if (!reset) begin
         if (req_valid && req_ready) board.take_byte(req_stream_byte);
         if (rsp_valid && rsp_ready) begin
            got.phase = rsp_parse_phase;
            got.kind = rsp_chunk_kind;
            got.data = rsp_payload_out;
            got.idat = rsp_compressed_valid;
            got.width = rsp_image_width;
            got.height = rsp_image_height;
            got.depth = rsp_sample_depth;
            got.colour = rsp_colour_kind;
            got.red = rsp_back_red;
            got.green = rsp_back_green;
            got.blue = rsp_back_blue;
            got.fault = rsp_fault_code;
            board.check_word(got);
         end
      end
   end

   // Result side. Ready comes in random bursts, with stalls of random length.
   // Once, early in the run, ready stays low for a long stretch while the sender keeps
   // offering bytes; the single output register fills and the block must hold off its
   // input until the stall ends.
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!long_hold_done && board.words_seen >= 120) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
      end
   end

   // Offers one byte and returns at the falling edge after it was taken. It is always
   // entered at a falling edge, so valid stays high without a break between bytes
   // unless an idle gap is inserted first.
   task automatic send_byte(input logic [7:0] value);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_stream_byte <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_random_bytes(input int count);
      repeat (count) send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic send_word32(input logic [31:0] value);
      for (int i = 3; i >= 0; i--) send_byte(value[8 * i +: 8]);
   endtask

   task automatic send_header(input logic [31:0] len, input logic [31:0] code);
      send_word32(len);
      send_word32(code);
   endtask

   task automatic send_signature();
      for (int i = 0; i < 8; i++) send_byte(PNG_MAGIC[63 - 8 * i -: 8]);
   endtask

   // Sends one well-formed chunk of the given type with random content. Lengths are
   // mostly the natural ones, with short and long variants mixed in.
   task automatic send_chunk(input logic [31:0] code);
      int         len;
      int         fill;
      int         entries;
      logic [7:0] colour;
      logic [7:0] val;
      fill = $urandom_range(0, 3);
      colour = COLOUR_GREY;
      case (code)
         TYPE_IHDR: begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 13;
            case ($urandom_range(0, 5))
               0:       colour = COLOUR_GREY;
               1:       colour = COLOUR_RGB;
               2:       colour = COLOUR_INDEXED;
               3:       colour = COLOUR_GREY_ALPHA;
               4:       colour = COLOUR_RGB_ALPHA;
               default: colour = 8'($urandom_range(0, 255));
            endcase
         end
         TYPE_PLTE: begin
            entries = $urandom_range(0, 20);
            len = 3 * entries;
            if (entries > pal_filled) pal_filled = entries;
         end
         TYPE_IDAT: begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 48);
         end
         TYPE_CHRM: len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : 32;
         TYPE_TIME: len = 7;
         TYPE_TEXT: len = $urandom_range(0, 30);
         TYPE_BKGD: begin
            if (cur_colour == COLOUR_INDEXED)
               len = (pal_filled == 0) ? 0 : $urandom_range(1, 3);
            else if (cur_colour == COLOUR_GREY || cur_colour == COLOUR_GREY_ALPHA)
               len = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4) : 2;
            else
               len = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 8) : 6;
         end
         TYPE_IEND: len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
         default: len = 0;
      endcase
      send_header(len, code);
      for (int k = 0; k < len; k++) begin
         val = 8'($urandom_range(0, 255));
         if (code == TYPE_IHDR && k == 9) begin
            val = colour;
         end else if (code == TYPE_IHDR && k < 8 && fill < 2) begin
            // Width and height at both extremes now and then.
            val = (fill == 0) ? 8'h00 : 8'hFF;
         end else if (code == TYPE_BKGD && cur_colour == COLOUR_INDEXED && k == 0) begin
            val = 8'($urandom_range(0, pal_filled - 1));
         end
         send_byte(val);
      end
      if (code == TYPE_IHDR) cur_colour = (len >= 10) ? colour : COLOUR_GREY;
      send_random_bytes(4);
   endtask

   // One complete file: signature, IHDR, one to six PLTE, data or ancillary chunks, IEND.
   task automatic send_file();
      send_signature();
      send_chunk(TYPE_IHDR);
      repeat ($urandom_range(1, 6)) begin
         case ($urandom_range(0, 5))
            0:       send_chunk(TYPE_PLTE);
            1:       send_chunk(TYPE_IDAT);
            2:       send_chunk(TYPE_CHRM);
            3:       send_chunk(TYPE_BKGD);
            4:       send_chunk(TYPE_TIME);
            default: send_chunk(TYPE_TEXT);
         endcase
      end
      send_chunk(TYPE_IEND);
   endtask

   initial begin
      int         pos;
      logic [31:0] bad_len;
      reset = 1'b1;
      req_valid = 1'b0;
      req_stream_byte = 8'h00;
      quiet = 1'b0;
      long_hold_done = 1'b0;
      bytes_sent = 0;
      cycle_count = 0;
      pal_filled = 0;
      cur_colour = COLOUR_GREY;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Shortest legal file: a zero-length IHDR goes straight to its CRC, which
      // carries the all-zero and all-one byte values, and IEND closes the file.
      send_signature();
      send_header(0, TYPE_IHDR);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_header(0, TYPE_IEND);
      send_random_bytes(4);

      // Random well-formed files, back to back.
      while (bytes_sent < RANDOM_BYTES) send_file();

      // Last part: no idle cycles on either side.
      quiet = 1'b1;
      send_file();

      // A fault is sticky until reset and reset is applied only once, so a single
      // fault, chosen at random, closes the run. Bytes after it must all report error.
      send_file();
      case ($urandom_range(1, 5))
         1: begin
            pos = $urandom_range(0, 7);
            for (int k = 0; k < pos; k++) send_byte(PNG_MAGIC[63 - 8 * k -: 8]);
            send_byte(PNG_MAGIC[63 - 8 * pos -: 8] ^ (8'd1 << $urandom_range(0, 7)));
         end
         2: begin
            // The first chunk of the file is not IHDR.
            send_signature();
            send_header($urandom_range(0, 20),
                        $urandom_range(0, 1) ? TYPE_IDAT
                                             : TYPE_IHDR ^ (32'd1 << $urandom_range(0, 31)));
         end
         3: begin
            send_signature();
            send_word32(32'h8000_0000 | $urandom);
         end
         4: begin
            case ($urandom_range(0, 2))
               0:       bad_len = PLTE_MAX_LEN + 3;
               1:       bad_len = 3 * $urandom_range(0, 255) + $urandom_range(1, 2);
               default: bad_len = 3 * $urandom_range(PAL_DEPTH + 1, 32'h2AAA_AAAA);
            endcase
            send_signature();
            send_chunk(TYPE_IHDR);
            send_header(bad_len, TYPE_PLTE);
         end
         default: begin
            // A second IHDR, or a type one bit away from a known one.
            send_signature();
            send_chunk(TYPE_IHDR);
            send_header($urandom_range(0, 20),
                        $urandom_range(0, 1) ? TYPE_IHDR
                                             : TYPE_BKGD ^ (32'd1 << $urandom_range(0, 31)));
         end
      endcase
      send_random_bytes(16);
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[png_chunk_stream_parser.f]
hdl/pngcsp_pkg.sv
hdl/pngcsp_palette.sv
hdl/png_chunk_stream_parser.sv
verif/png_parse_check_pkg.sv
verif/tb_top.sv
